### rtl/dsb_pkg.sv
// Shared constants and types for the delay-and-sum beamformer.
`default_nettype none
package dsb_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int DELAY_W       = 6;
  localparam int CHAN_COUNT    = 4;
  localparam int MAX_DELAY_DEF = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [DELAY_W-1:0]  delay_t;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_MIC2 = 2'd1,
    REG_MIC3 = 2'd2,
    REG_MIC4 = 2'd3
  } reg_idx_t;

endpackage
`default_nettype wire

### rtl/dsb_ram.sv
// Simple dual-port RAM, one write port, one registered read-first read port.
`default_nettype none
module dsb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/dsb_lane.sv
// One delay-line lane: circular history in RAM with a fill count standing in for a zero reset.
`default_nettype none
module dsb_lane #(
  parameter int DEPTH = 32,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire dsb_pkg::sample_t sample,
  input  wire logic [AW-1:0]    age,
  output dsb_pkg::sample_t      tap
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int SW   = AW + 1;

  logic [PW-1:0]    wp;
  logic [CNTW-1:0]  cnt;
  logic [SW-1:0]    diff;
  logic [PW-1:0]    raddr;
  logic [dsb_pkg::SAMPLE_W-1:0] rdata;
  dsb_pkg::sample_t cur_q;
  logic             direct_q;
  logic             filled_q;

  always_comb begin
    diff = SW'(wp) - SW'(age);
    if (diff[SW-1]) begin
      diff = diff + SW'(DEPTH);
    end
    raddr = diff[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      cnt <= '0;
    end else if (accept) begin
      wp  <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      cnt <= (cnt == CNTW'(DEPTH)) ? cnt : cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_q    <= sample;
      direct_q <= (age == '0);
      filled_q <= (SW'(cnt) >= SW'(age));
    end
  end

  dsb_ram #(
    .WIDTH (dsb_pkg::SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (sample),
    .re    (accept),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign tap = direct_q ? cur_q : (filled_q ? dsb_pkg::sample_t'(rdata) : '0);

endmodule
`default_nettype wire

### rtl/dsb_merge.sv
// Merge stage: sums the lane taps and divides by the mic count, truncating toward zero.
`default_nettype none
module dsb_merge (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic             four_mic_mode,
  input  wire dsb_pkg::sample_t tap_ref,
  input  wire dsb_pkg::sample_t tap2,
  input  wire dsb_pkg::sample_t tap3,
  input  wire dsb_pkg::sample_t tap4,
  output dsb_pkg::sample_t      beam
);

  localparam int W2 = dsb_pkg::SAMPLE_W + 1;
  localparam int W4 = dsb_pkg::SAMPLE_W + 2;

  logic signed [W2-1:0] sum2;
  logic signed [W2-1:0] adj2;
  logic signed [W4-1:0] sum4;
  logic signed [W4-1:0] adj4;
  dsb_pkg::sample_t     beam_next;

  always_comb begin
    sum2 = W2'(tap_ref) + W2'(tap2);
    sum4 = W4'(tap_ref) + W4'(tap2) + W4'(tap3) + W4'(tap4);
    // bias negative sums so the shift rounds toward zero
    adj2 = sum2 + (sum2[W2-1] ? W2'(1) : W2'(0));
    adj4 = sum4 + (sum4[W4-1] ? W4'(3) : W4'(0));
    beam_next = four_mic_mode ? adj4[W4-1:2] : adj2[W2-1:1];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beam <= beam_next;
    end
  end

endmodule
`default_nettype wire

### rtl/delay_and_sum_beamformer_core.sv
// Top level of the delay-and-sum beamformer: config registers, lanes, merge and handshake.
`default_nettype none
// Takes one four-channel frame per clock while the output is not stalled and
// returns one beam sample per frame. Each mic history is a RAM of 2*MAX_DELAY
// entries (the reference RAM holds MAX_DELAY); a frame passes through its
// registered read port and then the sum/divide register. Histories read as
// zero until filled, tracked by per-lane fill counts, so no clearing pass
// follows reset. Delay registers are clamped to +/-MAX_DELAY on write and
// read back clamped, sign extended. Change the configuration only while no
// frame is in flight.
module delay_and_sum_beamformer_core #(
  parameter int MAX_DELAY = dsb_pkg::MAX_DELAY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // ref_sample, mic2_sample, mic3_sample, mic4_sample
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // beam_sample
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int MIC_DEPTH = 2 * MAX_DELAY;
  localparam int AW        = $clog2(MIC_DEPTH + 1);
  localparam int CW        = AW + dsb_pkg::DELAY_W + 1;
  localparam logic signed [CW-1:0] LIM = CW'(MAX_DELAY);

  logic              four_mic_mode;
  dsb_pkg::delay_t   dly [3];
  logic              cfg_we;
  dsb_pkg::reg_idx_t reg_idx;

  logic              v1;
  logic              load_out;
  logic              accept;

  logic [AW-1:0]     age [3];
  logic signed [CW-1:0] age_full [3];
  dsb_pkg::sample_t  taps [dsb_pkg::CHAN_COUNT];
  dsb_pkg::sample_t  beam;

  function automatic dsb_pkg::delay_t clamp_delay(input logic [dsb_pkg::DELAY_W-1:0] v);
    logic signed [CW-1:0] x;
    x = CW'($signed(v));
    if (x > LIM) begin
      x = LIM;
    end else if (x < -LIM) begin
      x = -LIM;
    end
    return x[dsb_pkg::DELAY_W-1:0];
  endfunction

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = dsb_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      four_mic_mode <= 1'b0;
      dly[0]        <= '0;
      dly[1]        <= '0;
      dly[2]        <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        dsb_pkg::REG_MODE: four_mic_mode <= pwdata[0];
        dsb_pkg::REG_MIC2: dly[0] <= clamp_delay(pwdata[dsb_pkg::DELAY_W-1:0]);
        dsb_pkg::REG_MIC3: dly[1] <= clamp_delay(pwdata[dsb_pkg::DELAY_W-1:0]);
        dsb_pkg::REG_MIC4: dly[2] <= clamp_delay(pwdata[dsb_pkg::DELAY_W-1:0]);
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dsb_pkg::REG_MODE: prdata = {31'b0, four_mic_mode};
      dsb_pkg::REG_MIC2: prdata = 32'(dly[0]);
      dsb_pkg::REG_MIC3: prdata = 32'(dly[1]);
      dsb_pkg::REG_MIC4: prdata = 32'(dly[2]);
    endcase
  end

  // handshake: stage 1 holds RAM read data, m_tvalid marks the output register
  assign load_out = v1 && (!m_tvalid || m_tready);
  assign s_tready = !v1 || load_out;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        v1 <= 1'b1;
      end else if (load_out) begin
        v1 <= 1'b0;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  dsb_lane #(
    .DEPTH (MAX_DELAY),
    .AW    (AW)
  ) u_lane_ref (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sample (dsb_pkg::sample_t'(s_tdata[15:0])),
    .age    (AW'(MAX_DELAY)),
    .tap    (taps[0])
  );

  for (genvar i = 0; i < 3; i++) begin : g_mic
    assign age_full[i] = LIM + CW'(dly[i]);
    assign age[i]      = age_full[i][AW-1:0];

    dsb_lane #(
      .DEPTH (MIC_DEPTH),
      .AW    (AW)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .accept (accept),
      .sample (dsb_pkg::sample_t'(s_tdata[dsb_pkg::SAMPLE_W*(i+1) +: dsb_pkg::SAMPLE_W])),
      .age    (age[i]),
      .tap    (taps[i+1])
    );
  end

  dsb_merge u_merge (
    .clk           (clk),
    .load          (load_out),
    .four_mic_mode (four_mic_mode),
    .tap_ref       (taps[0]),
    .tap2          (taps[1]),
    .tap3          (taps[2]),
    .tap4          (taps[3]),
    .beam          (beam)
  );

  assign m_tdata = beam;

`ifndef SYNTHESIS
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted frame did not reach stage 1");

  a_load_sets_out: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_tvalid)
    else $error("merge load did not raise output valid");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    (v1 && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while pipeline is full and stalled");

  a_delay_clamped: assert property (@(posedge clk) disable iff (rst)
    (CW'(dly[0]) <= LIM) && (CW'(dly[0]) >= -LIM) &&
    (CW'(dly[1]) <= LIM) && (CW'(dly[1]) >= -LIM) &&
    (CW'(dly[2]) <= LIM) && (CW'(dly[2]) >= -LIM))
    else $error("delay register outside clamp range");
`endif

endmodule
`default_nettype wire
